// ===== hw/rtl/tss_pkg.sv =====
// Shared types, codes and constants of the training session sequencer.
package tss_pkg;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	// Summary phase length and the 5 cmH2O validity limit in 0.01 cmH2O
	localparam logic [31:0] SUMMARY_MS         = 32'd10000;
	localparam logic [15:0] PRESSURE_VALID_MIN = 16'd500;

	// Register defaults
	localparam logic [14:0] TARGET_LOW_RST      = 15'd2000;
	localparam logic [14:0] ZONE_HYSTERESIS_RST = 15'd200;
	localparam logic [15:0] HOLD_TIME_RST       = 16'd3000;
	localparam logic [23:0] PREP_TIME_RST       = 24'd3000;
	localparam logic [23:0] SET_TIME_RST        = 24'd30000;
	localparam logic [23:0] REST_TIME_RST       = 24'd10000;
	localparam logic [7:0]  TOTAL_SETS_RST      = 8'd3;
	localparam logic [9:0]  SAMPLE_INTERVAL_RST = 10'd20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET_LOW      = 3'd0,
		REG_ZONE_HYSTERESIS = 3'd1,
		REG_HOLD_TIME       = 3'd2,
		REG_PREP_TIME       = 3'd3,
		REG_SET_TIME        = 3'd4,
		REG_REST_TIME       = 3'd5,
		REG_TOTAL_SETS      = 3'd6,
		REG_SAMPLE_INTERVAL = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_EVENT  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		EV_BOOT_DONE   = 3'd0,
		EV_SHORT_PRESS = 3'd1,
		EV_LONG_PRESS  = 3'd2,
		EV_LINK_START  = 3'd3,
		EV_LINK_STOP   = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		MODE_BOOT    = 3'd0,
		MODE_STANDBY = 3'd1,
		MODE_PREP    = 3'd2,
		MODE_TRAIN   = 3'd3,
		MODE_REST    = 3'd4,
		MODE_SUMMARY = 3'd5,
		MODE_WEEKLY  = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		NOTICE_NONE         = 3'd0,
		NOTICE_ENTERED      = 3'd1,
		NOTICE_LEFT         = 3'd2,
		NOTICE_HOLD         = 3'd3,
		NOTICE_ENTERED_HOLD = 3'd4
	} notice_t;

	typedef struct packed {
		logic [31:0]        id;
		logic [31:0]        duration;
		logic [7:0]         orifice;
		logic [31:0]        count;
		logic signed [15:0] max_p;
		logic [47:0]        sum;
		logic [31:0]        valid_cnt;
		logic [31:0]        endur;
		logic [15:0]        hits;
	} metrics_t;

endpackage

// ===== hw/rtl/tss_if.sv =====
// Input and result channel interfaces of the training session sequencer.
interface tss_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [31:0]        now_ms;
	logic signed [15:0] pressure;
	logic [2:0]         event_code;
	logic [7:0]         payload;

	modport source (output valid, operation, now_ms, pressure, event_code, payload,
		input ready);
	modport sink (input valid, operation, now_ms, pressure, event_code, payload,
		output ready);
endinterface

interface tss_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         device_state;
	logic [2:0]         notice;
	logic               session_ended;
	logic [31:0]        session_id;
	logic [31:0]        duration_ms;
	logic [7:0]         orifice_level;
	logic [31:0]        sample_count;
	logic signed [15:0] max_pressure;
	logic [47:0]        pressure_sum;
	logic [31:0]        valid_samples;
	logic [31:0]        endurance_ms;
	logic [15:0]        target_hits;

	modport source (output valid, device_state, notice, session_ended, session_id,
		duration_ms, orifice_level, sample_count, max_pressure, pressure_sum,
		valid_samples, endurance_ms, target_hits, input ready);
	modport sink (input valid, device_state, notice, session_ended, session_id,
		duration_ms, orifice_level, sample_count, max_pressure, pressure_sum,
		valid_samples, endurance_ms, target_hits, output ready);
endinterface

// ===== hw/rtl/training_session_sequencer.sv =====
// Top level of the training session sequencer: session state machine and metrics.
//
//  channel   direction  transaction                         accepted when
//  in_ch     sink       tick / pressure sample / event      in_ch.valid & in_ch.ready
//  out_ch    source     state, notice and session metrics   out_ch.valid & out_ch.ready
//  cfg_*     sink       register write (index, data)        cfg_wr_en
//
// Each input transaction lands in the stage-1 register, is processed against the
// session state and leaves through the stage-2 result register, so one item per
// cycle is sustained while out_ch.ready stays high.
// The stage-2 register holds a result until taken; stage 1 advances whenever the result
// register is empty or being taken. in_ch.ready is combinational: that, or stage 1 empty.
// arst_n clears the control state and loads the register defaults; no clearing pass.
module training_session_sequencer
	import tss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	tss_in_if.sink                 in_ch,
	tss_out_if.source              out_ch
);

	// Configuration registers
	logic [14:0] target_low_q;
	logic [14:0] zone_hyst_q;
	logic [15:0] hold_time_q;
	logic [23:0] prep_time_q;
	logic [23:0] set_time_q;
	logic [23:0] rest_time_q;
	logic [7:0]  total_sets_q;
	logic [9:0]  sample_intv_q;

	// Stage 1: captured input transaction
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [31:0]        now_s1;
	logic signed [15:0] pressure_s1;
	logic [2:0]         event_s1;
	logic [7:0]         payload_s1;

	// Stage 2: result register
	logic        valid_s2;
	mode_t       mode_s2;
	notice_t     notice_s2;
	logic        ended_s2;
	metrics_t    metrics_s2;

	// Session state
	mode_t       mode_q, mode_d;
	logic [31:0] phase_start_q, phase_start_d;
	logic [7:0]  set_count_q, set_count_d;
	logic        in_zone_q, in_zone_d;
	logic [31:0] zone_enter_q, zone_enter_d;
	logic [31:0] last_tick_q, last_tick_d;
	logic        hold_counted_q, hold_counted_d;
	logic [31:0] fallback_id_q, fallback_id_d;
	logic [31:0] session_start_q, session_start_d;
	metrics_t    metrics_q, metrics_d;

	// Per-item working signals
	logic               advance;
	notice_t            notice_c;
	logic               ended_c;
	logic               start_c;
	logic               finish_c;
	logic [7:0]         start_orifice;
	logic [31:0]        cur_time;
	logic [31:0]        phase_elapsed;
	logic [31:0]        hold_elapsed;
	logic [7:0]         set_count_inc;
	logic signed [16:0] p_ext;
	logic signed [16:0] thr_enter;
	logic signed [16:0] thr_stay;
	logic               now_in;
	logic               entering;
	logic               hold_hit;
	logic [48:0]        sum_ext;

	// Stage 1 moves on when the result register is free or being drained
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_low_q  <= TARGET_LOW_RST;
			zone_hyst_q   <= ZONE_HYSTERESIS_RST;
			hold_time_q   <= HOLD_TIME_RST;
			prep_time_q   <= PREP_TIME_RST;
			set_time_q    <= SET_TIME_RST;
			rest_time_q   <= REST_TIME_RST;
			total_sets_q  <= TOTAL_SETS_RST;
			sample_intv_q <= SAMPLE_INTERVAL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TARGET_LOW:      target_low_q  <= cfg_data[14:0];
				REG_ZONE_HYSTERESIS: zone_hyst_q   <= cfg_data[14:0];
				REG_HOLD_TIME:       hold_time_q   <= cfg_data[15:0];
				REG_PREP_TIME:       prep_time_q   <= cfg_data[23:0];
				REG_SET_TIME:        set_time_q    <= cfg_data[23:0];
				REG_REST_TIME:       rest_time_q   <= cfg_data[23:0];
				REG_TOTAL_SETS:      total_sets_q  <= cfg_data[7:0];
				REG_SAMPLE_INTERVAL: sample_intv_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Input register: hold the transaction until it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1       <= in_ch.operation;
			now_s1      <= in_ch.now_ms;
			pressure_s1 <= in_ch.pressure;
			event_s1    <= in_ch.event_code;
			payload_s1  <= in_ch.payload;
		end
	end

	// Shared arithmetic for the current item
	assign cur_time      = (op_s1 == OP_TICK) ? now_s1 : last_tick_q;
	assign phase_elapsed = now_s1 - phase_start_q;
	assign set_count_inc = set_count_q + 8'd1;

	// Zone test: entry threshold, or the hysteresis threshold once inside (may go negative)
	assign p_ext     = {pressure_s1[15], pressure_s1};
	assign thr_enter = $signed({2'b00, target_low_q});
	assign thr_stay  = $signed({2'b00, target_low_q}) - $signed({2'b00, zone_hyst_q});
	assign now_in    = in_zone_q ? (p_ext >= thr_stay) : (p_ext >= thr_enter);
	assign entering  = now_in && !in_zone_q;

	// A fresh entry restarts the hold clock at the current time
	assign hold_elapsed = entering ? 32'd0 : (last_tick_q - zone_enter_q);
	assign hold_hit     = now_in && (entering || !hold_counted_q)
		&& (hold_elapsed >= {16'd0, hold_time_q});

	assign sum_ext = {1'b0, metrics_q.sum} + {33'd0, pressure_s1};

	// Next session state and result for the item in stage 1
	always_comb begin
		mode_d          = mode_q;
		phase_start_d   = phase_start_q;
		set_count_d     = set_count_q;
		in_zone_d       = in_zone_q;
		zone_enter_d    = zone_enter_q;
		last_tick_d     = last_tick_q;
		hold_counted_d  = hold_counted_q;
		fallback_id_d   = fallback_id_q;
		session_start_d = session_start_q;
		metrics_d       = metrics_q;
		notice_c        = NOTICE_NONE;
		ended_c         = 1'b0;
		start_c         = 1'b0;
		finish_c        = 1'b0;
		start_orifice   = 8'd1;

		if (valid_s1) begin
			case (op_s1)
				OP_TICK: begin
					last_tick_d = now_s1;
					case (mode_q)
						MODE_PREP: begin
							if (phase_elapsed >= {8'd0, prep_time_q}) mode_d = MODE_TRAIN;
						end
						MODE_TRAIN: begin
							if (phase_elapsed >= {8'd0, set_time_q}) begin
								set_count_d = set_count_inc;
								if (set_count_inc >= total_sets_q) finish_c = 1'b1;
								else mode_d = MODE_REST;
							end
						end
						MODE_REST: begin
							if (phase_elapsed >= {8'd0, rest_time_q}) mode_d = MODE_TRAIN;
						end
						MODE_SUMMARY: begin
							if (phase_elapsed >= SUMMARY_MS) mode_d = MODE_STANDBY;
						end
						default: ;
					endcase
				end
				OP_SAMPLE: begin
					// Samples only count during a train set
					if (mode_q == MODE_TRAIN) begin
						metrics_d.count = metrics_q.count + 32'd1;
						if (pressure_s1 > metrics_q.max_p) metrics_d.max_p = pressure_s1;
						if (pressure_s1 >= $signed(PRESSURE_VALID_MIN)) begin
							metrics_d.sum       = sum_ext[48] ? '1 : sum_ext[47:0];
							metrics_d.valid_cnt = metrics_q.valid_cnt + 32'd1;
						end
						if (now_in) begin
							if (entering) begin
								in_zone_d      = 1'b1;
								zone_enter_d   = last_tick_q;
								hold_counted_d = 1'b0;
							end
							metrics_d.endur = metrics_q.endur + {22'd0, sample_intv_q};
							if (hold_hit) begin
								metrics_d.hits = metrics_q.hits + 16'd1;
								hold_counted_d = 1'b1;
							end
							if (entering && hold_hit) notice_c = NOTICE_ENTERED_HOLD;
							else if (entering)        notice_c = NOTICE_ENTERED;
							else if (hold_hit)        notice_c = NOTICE_HOLD;
						end else if (in_zone_q) begin
							in_zone_d = 1'b0;
							notice_c  = NOTICE_LEFT;
						end
					end
				end
				OP_EVENT: begin
					case (event_s1)
						EV_BOOT_DONE: mode_d = MODE_STANDBY;
						EV_SHORT_PRESS: begin
							if (mode_q == MODE_STANDBY) start_c = 1'b1;
							else if (mode_q == MODE_SUMMARY) mode_d = MODE_STANDBY;
						end
						EV_LONG_PRESS: begin
							// Outside standby a long press always closes the session
							if (mode_q == MODE_STANDBY) mode_d = MODE_WEEKLY;
							else finish_c = 1'b1;
						end
						EV_LINK_START: begin
							if (mode_q == MODE_STANDBY) begin
								start_c       = 1'b1;
								start_orifice = payload_s1;
							end
						end
						EV_LINK_STOP: begin
							if (mode_q == MODE_TRAIN || mode_q == MODE_REST
								|| mode_q == MODE_PREP) finish_c = 1'b1;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		// Open a session: clear metrics, take the id from the time or the fallback counter
		if (start_c) begin
			metrics_d         = '0;
			metrics_d.orifice = start_orifice;
			metrics_d.id      = (cur_time != 32'd0) ? cur_time : fallback_id_q;
			fallback_id_d     = fallback_id_q + 32'd1;
			session_start_d   = cur_time;
			set_count_d       = 8'd0;
			in_zone_d         = 1'b0;
			hold_counted_d    = 1'b0;
			mode_d            = MODE_PREP;
		end

		// Close a session: stamp the duration and drop into summary
		if (finish_c) begin
			metrics_d.duration = cur_time - session_start_q;
			mode_d             = MODE_SUMMARY;
			ended_c            = 1'b1;
		end

		// Restart the phase clock only on a real change of mode
		if (mode_d != mode_q) phase_start_d = cur_time;
	end

	// Session state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_BOOT;
			phase_start_q   <= '0;
			set_count_q     <= '0;
			in_zone_q       <= 1'b0;
			zone_enter_q    <= '0;
			last_tick_q     <= '0;
			hold_counted_q  <= 1'b0;
			fallback_id_q   <= 32'd1;
			session_start_q <= '0;
			metrics_q       <= '0;
		end else if (advance) begin
			mode_q          <= mode_d;
			phase_start_q   <= phase_start_d;
			set_count_q     <= set_count_d;
			in_zone_q       <= in_zone_d;
			zone_enter_q    <= zone_enter_d;
			last_tick_q     <= last_tick_d;
			hold_counted_q  <= hold_counted_d;
			fallback_id_q   <= fallback_id_d;
			session_start_q <= session_start_d;
			metrics_q       <= metrics_d;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2    <= mode_d;
			notice_s2  <= notice_c;
			ended_s2   <= ended_c;
			metrics_s2 <= metrics_d;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.device_state  = mode_s2;
	assign out_ch.notice        = notice_s2;
	assign out_ch.session_ended = ended_s2;
	assign out_ch.session_id    = metrics_s2.id;
	assign out_ch.duration_ms   = metrics_s2.duration;
	assign out_ch.orifice_level = metrics_s2.orifice;
	assign out_ch.sample_count  = metrics_s2.count;
	assign out_ch.max_pressure  = metrics_s2.max_p;
	assign out_ch.pressure_sum  = metrics_s2.sum;
	assign out_ch.valid_samples = metrics_s2.valid_cnt;
	assign out_ch.endurance_ms  = metrics_s2.endur;
	assign out_ch.target_hits   = metrics_s2.hits;

endmodule
